// ----- design/i2cmbe_pkg.sv -----
// shared types, codes and helpers for the i2c master byte engine
package i2cmbe_pkg;

  localparam int unsigned TickW   = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned FuncW   = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned BitCntW = 4;

  localparam logic [TickW-1:0] SetupReset = 16'd2;
  localparam logic [TickW-1:0] HalfReset  = 16'd5;
  localparam logic [TickW-1:0] HoldReset  = 16'd4;

  localparam logic [BitCntW-1:0] BitsPerByte = 4'd8;
  localparam logic [ByteW-1:0]   MsbMask     = 8'h80;

  // command selector codes
  typedef enum logic [FuncW-1:0] {
    FUNC_NONE  = 3'd0,
    FUNC_START = 3'd1,
    FUNC_STOP  = 3'd2,
    FUNC_WRITE = 3'd3,
    FUNC_READ  = 3'd4
  } func_t;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SETUP = 2'd0,
    CFG_HALF  = 2'd1,
    CFG_HOLD  = 2'd2
  } cfg_idx_t;

  // sequencer phases
  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_S_SETUP  = 5'd1,
    PH_S_HIGH   = 5'd2,
    PH_S_HOLD   = 5'd3,
    PH_S_LOW    = 5'd4,
    PH_P_SETUP  = 5'd5,
    PH_P_HIGH   = 5'd6,
    PH_P_REL    = 5'd7,
    PH_W_SETUP  = 5'd8,
    PH_W_HIGH   = 5'd9,
    PH_W_LOW    = 5'd10,
    PH_W_ASETUP = 5'd11,
    PH_W_AHIGH  = 5'd12,
    PH_W_ALOW   = 5'd13,
    PH_R_REL    = 5'd14,
    PH_R_HIGH   = 5'd15,
    PH_R_LOW    = 5'd16,
    PH_R_GAP    = 5'd17,
    PH_R_ASETUP = 5'd18,
    PH_R_AHIGH  = 5'd19,
    PH_R_ALOW   = 5'd20
  } phase_t;

  // a zero delay counts as one tick
  function automatic logic [TickW-1:0] tick_delay(input logic [TickW-1:0] d);
    tick_delay = (d == '0) ? {{(TickW-1){1'b0}}, 1'b1} : d;
  endfunction

endpackage

// ----- design/i2c_master_byte_engine_top.sv -----
// i2c master byte engine: tick sequencer with input and result registers
// A tick passes the input register, then the result register.
// Throughput: one tick per cycle unless stalled; sequencer steps once per processed tick.
// Output stalls back up through the result register into the input register.
// Reset (synchronous, rst_n low): phase idle, both lines released, counters and shift
// registers cleared, delay registers back to setup 2, half 5, hold 4.
module i2c_master_byte_engine_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // tick input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [i2cmbe_pkg::FuncW-1:0]        in_func,
  input  logic [i2cmbe_pkg::ByteW-1:0]        in_tx_byte,
  input  logic                                in_master_nack,
  input  logic                                in_sda_in,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_scl_release,
  output logic                                out_sda_release,
  output logic                                out_busy_res,
  output logic                                out_done_res,
  output logic [i2cmbe_pkg::ByteW-1:0]        out_rx_byte,
  output logic                                out_slave_nack,
  output logic                                out_cmd_ignored,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [i2cmbe_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [i2cmbe_pkg::TickW-1:0]        cfg_data
);

  localparam int unsigned TickW   = i2cmbe_pkg::TickW;
  localparam int unsigned ByteW   = i2cmbe_pkg::ByteW;
  localparam int unsigned BitCntW = i2cmbe_pkg::BitCntW;

  // configuration registers
  logic [TickW-1:0] setup_ticks_r, half_ticks_r, hold_ticks_r;

  // input register
  logic                           s1_valid_r;
  logic [i2cmbe_pkg::FuncW-1:0]   s1_func_r;
  logic [ByteW-1:0]               s1_tx_byte_r;
  logic                           s1_master_nack_r;
  logic                           s1_sda_in_r;

  // sequencer state
  i2cmbe_pkg::phase_t phase_r, phase_nxt;
  logic [BitCntW-1:0] bit_count_r, bit_count_nxt;
  logic [TickW-1:0]   wait_count_r, wait_count_nxt;
  logic [ByteW-1:0]   tx_shift_r, tx_shift_nxt;
  logic [ByteW-1:0]   rx_shift_r, rx_shift_nxt;
  logic               scl_level_r, scl_level_nxt;
  logic               sda_level_r, sda_level_nxt;
  logic               ack_seen_r, ack_seen_nxt;
  logic               nack_request_r, nack_request_nxt;
  logic               done_nxt, ignored_nxt;

  // result register
  logic             out_valid_r;
  logic             out_scl_r, out_sda_r, out_busy_r, out_done_r;
  logic [ByteW-1:0] out_rx_byte_r;
  logic             out_slave_nack_r, out_ignored_r;

  logic s1_fire;
  logic is_cmd;

  // handshake: the tick in the input register is processed when the result register frees
  assign s1_fire   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_fire;
  assign cfg_ready = 1'b1;

  assign is_cmd = (s1_func_r == i2cmbe_pkg::FUNC_START) || (s1_func_r == i2cmbe_pkg::FUNC_STOP) ||
                  (s1_func_r == i2cmbe_pkg::FUNC_WRITE) || (s1_func_r == i2cmbe_pkg::FUNC_READ);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setup_ticks_r <= i2cmbe_pkg::SetupReset;
      half_ticks_r  <= i2cmbe_pkg::HalfReset;
      hold_ticks_r  <= i2cmbe_pkg::HoldReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        i2cmbe_pkg::CFG_SETUP: setup_ticks_r <= cfg_data;
        i2cmbe_pkg::CFG_HALF:  half_ticks_r  <= cfg_data;
        i2cmbe_pkg::CFG_HOLD:  hold_ticks_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_func_r        <= in_func;
      s1_tx_byte_r     <= in_tx_byte;
      s1_master_nack_r <= in_master_nack;
      s1_sda_in_r      <= in_sda_in;
    end
  end

  // next sequencer state for one tick
  always_comb begin
    phase_nxt        = phase_r;
    bit_count_nxt    = bit_count_r;
    wait_count_nxt   = wait_count_r;
    tx_shift_nxt     = tx_shift_r;
    rx_shift_nxt     = rx_shift_r;
    scl_level_nxt    = scl_level_r;
    sda_level_nxt    = sda_level_r;
    ack_seen_nxt     = ack_seen_r;
    nack_request_nxt = nack_request_r;
    done_nxt         = 1'b0;
    ignored_nxt      = 1'b0;

    if (phase_r == i2cmbe_pkg::PH_IDLE) begin
      // command launch
      unique case (s1_func_r)
        i2cmbe_pkg::FUNC_START: begin
          sda_level_nxt  = 1'b1;
          phase_nxt      = i2cmbe_pkg::PH_S_SETUP;
          wait_count_nxt = i2cmbe_pkg::tick_delay(setup_ticks_r);
        end
        i2cmbe_pkg::FUNC_STOP: begin
          sda_level_nxt  = 1'b0;
          phase_nxt      = i2cmbe_pkg::PH_P_SETUP;
          wait_count_nxt = i2cmbe_pkg::tick_delay(setup_ticks_r);
        end
        i2cmbe_pkg::FUNC_WRITE: begin
          tx_shift_nxt   = s1_tx_byte_r;
          bit_count_nxt  = '0;
          sda_level_nxt  = |(s1_tx_byte_r & i2cmbe_pkg::MsbMask);
          phase_nxt      = i2cmbe_pkg::PH_W_SETUP;
          wait_count_nxt = i2cmbe_pkg::tick_delay(setup_ticks_r);
        end
        i2cmbe_pkg::FUNC_READ: begin
          nack_request_nxt = s1_master_nack_r;
          rx_shift_nxt     = '0;
          bit_count_nxt    = '0;
          sda_level_nxt    = 1'b1;
          phase_nxt        = i2cmbe_pkg::PH_R_REL;
          wait_count_nxt   = i2cmbe_pkg::tick_delay(half_ticks_r);
        end
        default: ;
      endcase
    end else begin
      ignored_nxt = is_cmd;
      if (wait_count_r > {{(TickW-1){1'b0}}, 1'b1}) begin
        wait_count_nxt = wait_count_r - {{(TickW-1){1'b0}}, 1'b1};
      end else begin
        // step to the next phase once the wait has run out
        unique case (phase_r)
          i2cmbe_pkg::PH_S_SETUP, i2cmbe_pkg::PH_P_SETUP, i2cmbe_pkg::PH_W_SETUP,
          i2cmbe_pkg::PH_W_ASETUP, i2cmbe_pkg::PH_R_REL, i2cmbe_pkg::PH_R_GAP,
          i2cmbe_pkg::PH_R_ASETUP: begin
            scl_level_nxt  = 1'b1;
            wait_count_nxt = i2cmbe_pkg::tick_delay(half_ticks_r);
            unique case (phase_r)
              i2cmbe_pkg::PH_S_SETUP:  phase_nxt = i2cmbe_pkg::PH_S_HIGH;
              i2cmbe_pkg::PH_P_SETUP:  phase_nxt = i2cmbe_pkg::PH_P_HIGH;
              i2cmbe_pkg::PH_W_SETUP:  phase_nxt = i2cmbe_pkg::PH_W_HIGH;
              i2cmbe_pkg::PH_W_ASETUP: phase_nxt = i2cmbe_pkg::PH_W_AHIGH;
              i2cmbe_pkg::PH_R_ASETUP: phase_nxt = i2cmbe_pkg::PH_R_AHIGH;
              default:                 phase_nxt = i2cmbe_pkg::PH_R_HIGH;
            endcase
          end
          i2cmbe_pkg::PH_S_HIGH: begin
            sda_level_nxt  = 1'b0;
            phase_nxt      = i2cmbe_pkg::PH_S_HOLD;
            wait_count_nxt = i2cmbe_pkg::tick_delay(hold_ticks_r);
          end
          i2cmbe_pkg::PH_S_HOLD: begin
            scl_level_nxt  = 1'b0;
            phase_nxt      = i2cmbe_pkg::PH_S_LOW;
            wait_count_nxt = i2cmbe_pkg::tick_delay(half_ticks_r);
          end
          i2cmbe_pkg::PH_P_HIGH: begin
            sda_level_nxt  = 1'b1;
            phase_nxt      = i2cmbe_pkg::PH_P_REL;
            wait_count_nxt = i2cmbe_pkg::tick_delay(half_ticks_r);
          end
          i2cmbe_pkg::PH_W_HIGH: begin
            scl_level_nxt  = 1'b0;
            tx_shift_nxt   = {tx_shift_r[ByteW-2:0], 1'b0};
            bit_count_nxt  = bit_count_r + {{(BitCntW-1){1'b0}}, 1'b1};
            phase_nxt      = i2cmbe_pkg::PH_W_LOW;
            wait_count_nxt = i2cmbe_pkg::tick_delay(half_ticks_r);
          end
          i2cmbe_pkg::PH_W_LOW: begin
            wait_count_nxt = i2cmbe_pkg::tick_delay(setup_ticks_r);
            if (bit_count_r < i2cmbe_pkg::BitsPerByte) begin
              sda_level_nxt = |(tx_shift_r & i2cmbe_pkg::MsbMask);
              phase_nxt     = i2cmbe_pkg::PH_W_SETUP;
            end else begin
              sda_level_nxt = 1'b1;
              phase_nxt     = i2cmbe_pkg::PH_W_ASETUP;
            end
          end
          i2cmbe_pkg::PH_W_AHIGH: begin
            ack_seen_nxt   = s1_sda_in_r;
            scl_level_nxt  = 1'b0;
            phase_nxt      = i2cmbe_pkg::PH_W_ALOW;
            wait_count_nxt = i2cmbe_pkg::tick_delay(half_ticks_r);
          end
          i2cmbe_pkg::PH_R_HIGH: begin
            rx_shift_nxt   = {rx_shift_r[ByteW-2:0], s1_sda_in_r};
            scl_level_nxt  = 1'b0;
            bit_count_nxt  = bit_count_r + {{(BitCntW-1){1'b0}}, 1'b1};
            phase_nxt      = i2cmbe_pkg::PH_R_LOW;
            wait_count_nxt = i2cmbe_pkg::tick_delay(half_ticks_r);
          end
          i2cmbe_pkg::PH_R_LOW: begin
            if (bit_count_r < i2cmbe_pkg::BitsPerByte) begin
              phase_nxt      = i2cmbe_pkg::PH_R_GAP;
              wait_count_nxt = i2cmbe_pkg::tick_delay(half_ticks_r);
            end else begin
              sda_level_nxt  = nack_request_r;
              phase_nxt      = i2cmbe_pkg::PH_R_ASETUP;
              wait_count_nxt = i2cmbe_pkg::tick_delay(setup_ticks_r);
            end
          end
          i2cmbe_pkg::PH_R_AHIGH: begin
            scl_level_nxt  = 1'b0;
            phase_nxt      = i2cmbe_pkg::PH_R_ALOW;
            wait_count_nxt = i2cmbe_pkg::tick_delay(half_ticks_r);
          end
          i2cmbe_pkg::PH_R_ALOW: begin
            sda_level_nxt  = 1'b1;
            phase_nxt      = i2cmbe_pkg::PH_IDLE;
            wait_count_nxt = '0;
            done_nxt       = 1'b1;
          end
          // final low half of start, stop release and write ack low end the sequence
          default: begin
            phase_nxt      = i2cmbe_pkg::PH_IDLE;
            wait_count_nxt = '0;
            done_nxt       = 1'b1;
          end
        endcase
      end
    end
  end

  // sequencer state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= i2cmbe_pkg::PH_IDLE;
      bit_count_r    <= '0;
      wait_count_r   <= '0;
      tx_shift_r     <= '0;
      rx_shift_r     <= '0;
      scl_level_r    <= 1'b1;
      sda_level_r    <= 1'b1;
      ack_seen_r     <= 1'b0;
      nack_request_r <= 1'b0;
    end else if (s1_fire) begin
      phase_r        <= phase_nxt;
      bit_count_r    <= bit_count_nxt;
      wait_count_r   <= wait_count_nxt;
      tx_shift_r     <= tx_shift_nxt;
      rx_shift_r     <= rx_shift_nxt;
      scl_level_r    <= scl_level_nxt;
      sda_level_r    <= sda_level_nxt;
      ack_seen_r     <= ack_seen_nxt;
      nack_request_r <= nack_request_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_scl_r        <= scl_level_nxt;
      out_sda_r        <= sda_level_nxt;
      out_busy_r       <= (phase_nxt != i2cmbe_pkg::PH_IDLE);
      out_done_r       <= done_nxt;
      out_rx_byte_r    <= rx_shift_nxt;
      out_slave_nack_r <= ack_seen_nxt;
      out_ignored_r    <= ignored_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_scl_release = out_scl_r;
  assign out_sda_release = out_sda_r;
  assign out_busy_res    = out_busy_r;
  assign out_done_res    = out_done_r;
  assign out_rx_byte     = out_rx_byte_r;
  assign out_slave_nack  = out_slave_nack_r;
  assign out_cmd_ignored = out_ignored_r;

endmodule

// ----- tb/i2c_master_byte_engine_top_tb.sv -----
// self-checking testbench for the i2c master byte engine: tick stimulus, line predictor, checker
module i2c_master_byte_engine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cmbe_pkg::*;

  // selector codes outside the command set, ignored by the engine
  localparam logic [FuncW-1:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [FuncW-1:0] FUNC_SPARE_HI = 3'd7;
  // index with no register behind it
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;
  localparam logic [TickW-1:0] TICKS_MAX = 16'hFFFF;
  localparam int unsigned PRINT_CAP = 40;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [ByteW-1:0] txb;
    logic             mn;
    logic             sda;
  } tick_t;

  typedef struct packed {
    logic             scl;
    logic             sda;
    logic             busy;
    logic             done;
    logic [ByteW-1:0] rx;
    logic             ack;
    logic             ign;
  } line_t;

  typedef struct packed {
    phase_t             ph;
    logic [BitCntW-1:0] bits;
    logic [TickW-1:0]   wcnt;
    logic [ByteW-1:0]   tx;
    logic [ByteW-1:0]   rx;
    logic               scl;
    logic               sda;
    logic               ack;
    logic               nreq;
  } eng_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [FuncW-1:0]   in_func = '0;
  logic [ByteW-1:0]   in_tx_byte = '0;
  logic               in_master_nack = 1'b0;
  logic               in_sda_in = 1'b1;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_scl_release;
  logic               out_sda_release;
  logic               out_busy_res;
  logic               out_done_res;
  logic [ByteW-1:0]   out_rx_byte;
  logic               out_slave_nack;
  logic               out_cmd_ignored;

  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [TickW-1:0]   cfg_data = '0;

  // predictor copy of the delay registers and the sequencer
  logic [TickW-1:0] dly_setup;
  logic [TickW-1:0] dly_half;
  logic [TickW-1:0] dly_hold;
  eng_t             eng;

  tick_t tick_q[$];
  line_t line_q[$];
  tick_t drv_tick;
  line_t want;

  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned n_err = 0;
  int unsigned n_seen = 0;

  i2c_master_byte_engine_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_tx_byte      (in_tx_byte),
    .in_master_nack  (in_master_nack),
    .in_sda_in       (in_sda_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_scl_release (out_scl_release),
    .out_sda_release (out_sda_release),
    .out_busy_res    (out_busy_res),
    .out_done_res    (out_done_res),
    .out_rx_byte     (out_rx_byte),
    .out_slave_nack  (out_slave_nack),
    .out_cmd_ignored (out_cmd_ignored),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #16_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // a delay of zero still waits one tick
  function automatic logic [TickW-1:0] arm(input logic [TickW-1:0] d);
    return (d == '0) ? TickW'(1) : d;
  endfunction

  // one tick of the line sequencer
  function automatic void line_tick(inout eng_t s, input tick_t t, output line_t r);
    r.ign = 1'b0;
    r.done = 1'b0;
    if (s.ph == PH_IDLE) begin
      case (t.func)
        FUNC_START: begin
          s.sda = 1'b1;
          s.ph = PH_S_SETUP;
          s.wcnt = arm(dly_setup);
        end
        FUNC_STOP: begin
          s.sda = 1'b0;
          s.ph = PH_P_SETUP;
          s.wcnt = arm(dly_setup);
        end
        FUNC_WRITE: begin
          s.tx = t.txb;
          s.bits = '0;
          s.sda = t.txb[ByteW-1];
          s.ph = PH_W_SETUP;
          s.wcnt = arm(dly_setup);
        end
        FUNC_READ: begin
          s.nreq = t.mn;
          s.rx = '0;
          s.bits = '0;
          s.sda = 1'b1;
          s.ph = PH_R_REL;
          s.wcnt = arm(dly_half);
        end
        default: ;
      endcase
    end else begin
      r.ign = (t.func >= FUNC_START) && (t.func <= FUNC_READ);
      if (s.wcnt > 1) begin
        s.wcnt = s.wcnt - 1'b1;
      end else begin
        // wait over: take the next step of the sequence
        case (s.ph)
          PH_S_SETUP, PH_P_SETUP, PH_W_SETUP, PH_W_ASETUP, PH_R_REL, PH_R_GAP,
          PH_R_ASETUP: begin
            s.scl = 1'b1;
            case (s.ph)
              PH_S_SETUP:  s.ph = PH_S_HIGH;
              PH_P_SETUP:  s.ph = PH_P_HIGH;
              PH_W_SETUP:  s.ph = PH_W_HIGH;
              PH_W_ASETUP: s.ph = PH_W_AHIGH;
              PH_R_ASETUP: s.ph = PH_R_AHIGH;
              default:     s.ph = PH_R_HIGH;
            endcase
            s.wcnt = arm(dly_half);
          end
          PH_S_HIGH: begin
            s.sda = 1'b0;
            s.ph = PH_S_HOLD;
            s.wcnt = arm(dly_hold);
          end
          PH_S_HOLD: begin
            s.scl = 1'b0;
            s.ph = PH_S_LOW;
            s.wcnt = arm(dly_half);
          end
          PH_P_HIGH: begin
            s.sda = 1'b1;
            s.ph = PH_P_REL;
            s.wcnt = arm(dly_half);
          end
          PH_W_HIGH: begin
            s.scl = 1'b0;
            s.tx = s.tx << 1;
            s.bits = s.bits + 1'b1;
            s.ph = PH_W_LOW;
            s.wcnt = arm(dly_half);
          end
          PH_W_LOW: begin
            // next data bit, or release for the slave ack
            s.sda = (s.bits < BitsPerByte) ? s.tx[ByteW-1] : 1'b1;
            s.ph = (s.bits < BitsPerByte) ? PH_W_SETUP : PH_W_ASETUP;
            s.wcnt = arm(dly_setup);
          end
          PH_W_AHIGH: begin
            s.ack = t.sda;
            s.scl = 1'b0;
            s.ph = PH_W_ALOW;
            s.wcnt = arm(dly_half);
          end
          PH_R_HIGH: begin
            s.rx = {s.rx[ByteW-2:0], t.sda};
            s.scl = 1'b0;
            s.bits = s.bits + 1'b1;
            s.ph = PH_R_LOW;
            s.wcnt = arm(dly_half);
          end
          PH_R_LOW: begin
            if (s.bits < BitsPerByte) begin
              s.ph = PH_R_GAP;
              s.wcnt = arm(dly_half);
            end else begin
              s.sda = s.nreq;
              s.ph = PH_R_ASETUP;
              s.wcnt = arm(dly_setup);
            end
          end
          PH_R_AHIGH: begin
            s.scl = 1'b0;
            s.ph = PH_R_ALOW;
            s.wcnt = arm(dly_half);
          end
          PH_R_ALOW: begin
            s.sda = 1'b1;
            s.ph = PH_IDLE;
            s.wcnt = '0;
            r.done = 1'b1;
          end
          default: begin
            s.ph = PH_IDLE;
            s.wcnt = '0;
            r.done = 1'b1;
          end
        endcase
      end
    end
    r.scl = s.scl;
    r.sda = s.sda;
    r.busy = (s.ph != PH_IDLE);
    r.rx = s.rx;
    r.ack = s.ack;
  endfunction

  // queue one tick and the line state it should produce
  task automatic push_tick(input logic [FuncW-1:0] f, input logic [ByteW-1:0] b,
                           input logic mn, input logic sda);
    tick_t t;
    line_t r;
    t.func = f;
    t.txb = b;
    t.mn = mn;
    t.sda = sda;
    line_tick(eng, t, r);
    tick_q.push_back(t);
    line_q.push_back(r);
  endtask

  task automatic push_rand(input logic [FuncW-1:0] f);
    push_tick(f, ByteW'($urandom), 1'($urandom), 1'($urandom));
  endtask

  function automatic logic [FuncW-1:0] rand_cmd();
    return FuncW'($urandom_range(FUNC_READ, FUNC_START));
  endfunction

  // tick until the engine is idle, optionally dropping a command on the finishing tick
  task automatic run_out(input bit cmd_on_last);
    eng_t  peek;
    tick_t t;
    line_t r;
    while (eng.ph != PH_IDLE) begin
      peek = eng;
      t = '0;
      line_tick(peek, t, r);
      if (cmd_on_last && r.done) begin
        push_rand(rand_cmd());
      end else begin
        push_rand(FUNC_NONE);
      end
    end
  endtask

  // random command sequences with random line levels and some noise
  task automatic rand_traffic(input int unsigned n);
    int unsigned cnt;
    int unsigned roll;
    cnt = 0;
    while (cnt < n) begin
      roll = $urandom_range(99);
      if (eng.ph == PH_IDLE) begin
        if (roll < 75) begin
          push_rand(rand_cmd());
          cnt++;
        end else if (roll < 88) begin
          push_rand(FUNC_NONE);
        end else begin
          push_rand(FuncW'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO)));
        end
      end else begin
        if (roll < 4) begin
          push_rand(rand_cmd());
        end else if (roll < 7) begin
          push_rand(FuncW'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO)));
        end else begin
          push_rand(FUNC_NONE);
        end
        cnt++;
      end
    end
    run_out(1'b0);
  endtask

  task automatic drain();
    do @(posedge clk); while (line_q.size() != 0);
  endtask

  // register write over the config channel, engine idle
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [TickW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SETUP: dly_setup = val;
      CFG_HALF:  dly_half = val;
      CFG_HOLD:  dly_hold = val;
      default: ;
    endcase
  endtask

  task automatic cfg_all(input logic [TickW-1:0] su, input logic [TickW-1:0] hf,
                         input logic [TickW-1:0] ho);
    cfg_write(CFG_SETUP, su);
    cfg_write(CFG_HALF, hf);
    cfg_write(CFG_HOLD, ho);
  endtask

  task automatic report_mismatch(input string what, input int unsigned exp_v,
                                 input int unsigned got_v);
    if (n_err < PRINT_CAP) begin
      $display("%0t mismatch on result %0d, %s: expected %0h got %0h",
               $realtime, n_seen, what, exp_v, got_v);
    end
    n_err++;
  endtask

  // tick driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        drv_tick = tick_q.pop_front();
        in_valid <= 1'b1;
        in_func <= drv_tick.func;
        in_tx_byte <= drv_tick.txb;
        in_master_nack <= drv_tick.mn;
        in_sda_in <= drv_tick.sda;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor and checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (line_q.size() == 0) begin
        report_mismatch("unexpected transfer", 0, 1);
      end else begin
        want = line_q.pop_front();
        if (out_scl_release !== want.scl)
          report_mismatch("scl_release", want.scl, out_scl_release);
        if (out_sda_release !== want.sda)
          report_mismatch("sda_release", want.sda, out_sda_release);
        if (out_busy_res !== want.busy)
          report_mismatch("busy_res", want.busy, out_busy_res);
        if (out_done_res !== want.done)
          report_mismatch("done_res", want.done, out_done_res);
        if (out_rx_byte !== want.rx)
          report_mismatch("rx_byte", want.rx, out_rx_byte);
        if (out_slave_nack !== want.ack)
          report_mismatch("slave_nack", want.ack, out_slave_nack);
        if (out_cmd_ignored !== want.ign)
          report_mismatch("cmd_ignored", want.ign, out_cmd_ignored);
      end
      n_seen++;
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // stimulus sequence
  initial begin
    dly_setup = SetupReset;
    dly_half = HalfReset;
    dly_hold = HoldReset;
    eng = '0;
    eng.ph = PH_IDLE;
    eng.scl = 1'b1;
    eng.sda = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    gap_pct = 38;
    stall_pct = 47;

    // directed: reset delays, every command, spare selectors, drops while busy
    push_tick(FUNC_NONE, 8'h00, 1'b0, 1'b0);
    push_tick(FUNC_NONE, 8'hFF, 1'b1, 1'b1);
    push_tick(FUNC_SPARE_LO, 8'h00, 1'b0, 1'b1);
    push_tick(FUNC_SPARE_HI, 8'hFF, 1'b1, 1'b0);
    push_tick(FUNC_START, 8'h5A, 1'b0, 1'b1);
    push_tick(FUNC_WRITE, 8'hFF, 1'b1, 1'b1);
    push_tick(FUNC_SPARE_HI, 8'h00, 1'b0, 1'b0);
    push_tick(FUNC_NONE, 8'h00, 1'b0, 1'b1);
    run_out(1'b0);
    push_tick(FUNC_WRITE, 8'hFF, 1'b0, 1'b1);
    run_out(1'b0);
    push_tick(FUNC_WRITE, 8'h00, 1'b1, 1'b0);
    run_out(1'b0);
    push_tick(FUNC_WRITE, 8'hA5, 1'b0, 1'b0);
    run_out(1'b1);
    push_tick(FUNC_READ, 8'h00, 1'b0, 1'b1);
    run_out(1'b0);
    push_tick(FUNC_READ, 8'hFF, 1'b1, 1'b0);
    push_tick(FUNC_STOP, 8'h00, 1'b0, 1'b1);
    run_out(1'b0);
    push_tick(FUNC_STOP, 8'h3C, 1'b1, 1'b0);
    run_out(1'b1);
    drain();

    // shortest delays
    cfg_all(16'd1, 16'd1, 16'd1);
    rand_traffic(300);
    drain();

    // zero delays act as one tick; the spare index changes nothing
    gap_pct = 47;
    stall_pct = 38;
    cfg_all(16'd0, 16'd0, 16'd0);
    cfg_write(CFG_SPARE, TICKS_MAX);
    rand_traffic(200);
    drain();

    cfg_all(16'd2, 16'd3, 16'd1);
    rand_traffic(150);
    drain();

    // no idling from here on
    gap_pct = 0;
    stall_pct = 0;
    cfg_all(16'($urandom_range(4, 1)), 16'($urandom_range(4, 1)),
            16'($urandom_range(4, 1)));
    rand_traffic(150);
    drain();

    // long delays, one start sequence with a read dropped while busy
    cfg_all(16'd20, 16'd20, 16'd20);
    push_rand(FUNC_START);
    push_rand(FUNC_READ);
    run_out(1'b1);
    drain();

    repeat (10) @(posedge clk);
    if (n_err == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/i2cmbe_pkg.sv
design/i2c_master_byte_engine_top.sv
tb/i2c_master_byte_engine_top_tb.sv
